FILE: design/nssm_pkg.sv
`default_nettype none
package nssm_pkg;

	localparam int KIND_BITS  = 2;
	localparam int STATE_BITS = 4;
	localparam int SYM_BITS   = 8;
	localparam int MASK_BITS  = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [KIND_BITS-1:0]    kind_t;
	typedef logic [STATE_BITS-1:0]   state_idx_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam kind_t KIND_ADD    = 2'd0;
	localparam kind_t KIND_BEGIN  = 2'd1;
	localparam kind_t KIND_SYMBOL = 2'd2;
	localparam kind_t KIND_END    = 2'd3;

	localparam cfg_idx_t CFG_START_STATE = 2'd0;
	localparam cfg_idx_t CFG_ACCEPT_MASK = 2'd1;

endpackage
`default_nettype wire

FILE: design/nfa_symbol_stream_matcher.sv
// Add, begin and end words leave busy low; done rises in the cycle after an end word.
// A symbol word raises busy while the store is scanned one entry
// per cycle through its single registered read port, then the new set is committed.
// A symbol word with an empty store clears the active set and leaves busy low.
// The receiver cannot stall: each result shows on done for exactly one cycle.
// arst_n clears control, counters, the active set, flags and registers; the store is not cleared.
`default_nettype none
module nfa_symbol_stream_matcher import nssm_pkg::*; #(
	parameter int NUM_STATES      = 16,
	parameter int MAX_TRANSITIONS = 64,
	parameter int SYMBOL_BITS     = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [KIND_BITS-1:0]     kind,
	input  wire logic [STATE_BITS-1:0]    from_state,
	input  wire logic [SYM_BITS-1:0]      symbol,
	input  wire logic [STATE_BITS-1:0]    to_state,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                          done,
	output logic                          accepted,
	output logic                          transitions_dropped
);

	localparam int SB = (SYMBOL_BITS < SYM_BITS) ? SYMBOL_BITS : SYM_BITS;
	localparam int CW = $clog2(MAX_TRANSITIONS + 1);
	localparam int IW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int EW = 2 * STATE_BITS + SB;
	localparam int AW = (NUM_STATES < MASK_BITS) ? NUM_STATES : MASK_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	typedef logic [NUM_STATES-1:0] set_t;

	function automatic set_t state_bit(input logic [STATE_BITS-1:0] s);
		set_t b;
		for (int k = 0; k < NUM_STATES; k++) begin
			b[k] = (int'(s) == k);
		end
		return b;
	endfunction

	logic [EW-1:0]          mem [MAX_TRANSITIONS];
	logic [EW-1:0]          rd_data_s1;
	logic                   rd_vld_s1;
	logic [1:0]             state_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          idx_q;
	logic [SB-1:0]          sym_q;
	set_t                   active_q;
	set_t                   next_q;
	logic                   drop_q;
	logic [STATE_BITS-1:0]  start_state_q;
	logic [MASK_BITS-1:0]   accept_mask_q;
	logic                   done_q;
	logic                   accepted_q;

	logic                   take;
	logic                   wr_en;
	logic [CW-1:0]          last_cnt;
	logic [IW-1:0]          last_idx;
	logic [STATE_BITS-1:0]  e_src;
	logic [SB-1:0]          e_sym;
	logic [STATE_BITS-1:0]  e_dst;
	set_t                   hit_vec;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;
	assign wr_en     = take && (kind == KIND_ADD) && (count_q < CW'(MAX_TRANSITIONS));
	assign last_cnt  = count_q - CW'(1);
	assign last_idx  = last_cnt[IW-1:0];

	assign e_src = rd_data_s1[EW-1 -: STATE_BITS];
	assign e_sym = rd_data_s1[STATE_BITS +: SB];
	assign e_dst = rd_data_s1[STATE_BITS-1:0];

	always_comb begin
		hit_vec = '0;
		if (rd_vld_s1 && (e_sym == sym_q) && ((active_q & state_bit(e_src)) != '0)) begin
			hit_vec = state_bit(e_dst);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= {from_state, symbol[SB-1:0], to_state};
		end
		rd_data_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			sym_q         <= '0;
			active_q      <= '0;
			next_q        <= '0;
			drop_q        <= 1'b0;
			start_state_q <= '0;
			accept_mask_q <= '0;
			done_q        <= 1'b0;
			accepted_q    <= 1'b0;
			rd_vld_s1     <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			done_q    <= take && (kind == KIND_END);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START_STATE) begin
					start_state_q <= cfg_data[STATE_BITS-1:0];
				end else if (cfg_index == CFG_ACCEPT_MASK) begin
					accept_mask_q <= cfg_data[MASK_BITS-1:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (kind)
							KIND_ADD: begin
								if (wr_en) begin
									count_q <= count_q + CW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							KIND_BEGIN: begin
								active_q <= state_bit(start_state_q);
							end
							KIND_SYMBOL: begin
								if (count_q == '0) begin
									active_q <= '0;
								end else begin
									sym_q   <= symbol[SB-1:0];
									next_q  <= '0;
									idx_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							KIND_END: begin
								accepted_q <= |(active_q[AW-1:0] & accept_mask_q[AW-1:0]);
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					next_q <= next_q | hit_vec;
					idx_q  <= idx_q + IW'(1);
					if (idx_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					active_q <= next_q | hit_vec;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done                = done_q;
	assign accepted            = accepted_q;
	assign transitions_dropped = drop_q;

endmodule
`default_nettype wire

FILE: design/nssm_checker.sv
`default_nettype none
module nssm_checker import nssm_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic [KIND_BITS-1:0]    kind,
	input wire logic                    cfg_valid,
	input wire logic                    cfg_ready,
	input wire logic                    done,
	input wire logic                    transitions_dropped
);

	a_done_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (kind == KIND_END)))
		else $error("result without an end word");

	a_end_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_END)) |=> done)
		else $error("end word gave no result");

	a_busy_from_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (kind == KIND_SYMBOL)))
		else $error("busy raised by a word other than a symbol");

	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(transitions_dropped) |-> transitions_dropped)
		else $error("drop flag cleared");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind nfa_symbol_stream_matcher nssm_checker u_nssm_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.start               (start),
	.busy                (busy),
	.kind                (kind),
	.cfg_valid           (cfg_valid),
	.cfg_ready           (cfg_ready),
	.done                (done),
	.transitions_dropped (transitions_dropped)
);
`default_nettype wire

FILE: dv/nfa_symbol_stream_matcher_tb.sv
module nfa_symbol_stream_matcher_tb;
	import nssm_pkg::*;

	localparam int NSTATES       = 16;
	localparam int STORE_DEPTH   = 64;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 70;

	localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
	localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic accepted;
		logic dropped;
	} verdict_t;

	typedef struct packed {
		logic     fixed;
		verdict_t v;
	} typed_t;

	localparam typed_t EXP_PREDICTED = 3'b000;
	localparam typed_t EXP_REJECTED  = 3'b100;
	localparam typed_t EXP_ACCEPTED  = 3'b110;

	typedef struct packed {
		logic                     is_cfg;
		cfg_idx_t                 idx;
		logic [CFG_DATA_BITS-1:0] data;
		kind_t                    kind;
		state_idx_t               src;
		logic [SYM_BITS-1:0]      sym;
		state_idx_t               dst;
		typed_t                   exp;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [KIND_BITS-1:0]     kind;
	logic [STATE_BITS-1:0]    from_state;
	logic [SYM_BITS-1:0]      symbol;
	logic [STATE_BITS-1:0]    to_state;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     done;
	logic                     accepted;
	logic                     transitions_dropped;

	nfa_symbol_stream_matcher u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.kind                (kind),
		.from_state          (from_state),
		.symbol              (symbol),
		.to_state            (to_state),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.done                (done),
		.accepted            (accepted),
		.transitions_dropped (transitions_dropped)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	state_idx_t          tr_src [STORE_DEPTH];
	logic [SYM_BITS-1:0] tr_sym [STORE_DEPTH];
	state_idx_t          tr_dst [STORE_DEPTH];
	int                  tr_count = 0;
	logic [NSTATES-1:0]  active_states = '0;
	logic                drop_seen = 1'b0;
	state_idx_t          start_reg = '0;
	logic [MASK_BITS-1:0] accept_reg = '0;

	verdict_t verdict_q [$];
	typed_t   typed_q [$];
	int       errors = 0;
	int       stall_cycles = 0;
	int       items_sent = 0;
	int       adds_sent = 0;
	bit       calm = 1'b0;
	logic [SYM_BITS-1:0] sym_pool [4];
	row_t     dir_rows [23];

	task automatic nfa_advance(input kind_t k, input state_idx_t s,
			input logic [SYM_BITS-1:0] c, input state_idx_t d,
			output bit has_v, output verdict_t v);
		logic [NSTATES-1:0] nxt;
		has_v = 1'b0;
		v = '0;
		nxt = '0;
		case (k)
			KIND_ADD: begin
				if (tr_count < STORE_DEPTH) begin
					tr_src[tr_count] = s;
					tr_sym[tr_count] = c;
					tr_dst[tr_count] = d;
					tr_count++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			KIND_BEGIN: begin
				active_states = '0;
				active_states[start_reg] = 1'b1;
			end
			KIND_SYMBOL: begin
				for (int i = 0; i < tr_count; i++)
					if (active_states[tr_src[i]] && tr_sym[i] == c)
						nxt[tr_dst[i]] = 1'b1;
				active_states = nxt;
			end
			KIND_END: begin
				has_v = 1'b1;
				v.accepted = |(active_states & accept_reg);
				v.dropped = drop_seen;
			end
		endcase
	endtask

	task automatic flag_error(input string msg);
		if (errors < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin : check_and_predict
		bit       has_v;
		verdict_t v;
		verdict_t want;
		typed_t   t;
		if (arst_n) begin
			if (done) begin
				if (verdict_q.size() == 0) begin
					flag_error($sformatf("unexpected result accepted=%0b dropped=%0b",
						accepted, transitions_dropped));
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want.accepted)
						flag_error($sformatf("accepted exp %0b got %0b",
							want.accepted, accepted));
					if (transitions_dropped !== want.dropped)
						flag_error($sformatf("transitions_dropped exp %0b got %0b",
							want.dropped, transitions_dropped));
				end
			end
			if (start && !busy) begin
				t = typed_q.pop_front();
				nfa_advance(kind, from_state, symbol, to_state, has_v, v);
				if (has_v)
					verdict_q = {verdict_q, (t.fixed ? t.v : v)};
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_STATE: start_reg = cfg_data[STATE_BITS-1:0];
					CFG_ACCEPT_MASK: accept_reg = cfg_data[MASK_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		return ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 80);
	endfunction

	function automatic logic [SYM_BITS-1:0] pick_symbol();
		return ($urandom_range(9) < 8) ? sym_pool[$urandom_range(3)] : SYM_BITS'($urandom);
	endfunction

	task automatic send(input kind_t k, input state_idx_t s, input logic [SYM_BITS-1:0] c,
			input state_idx_t d, input typed_t t);
		if (!calm && $urandom_range(99) < 36) begin
			start <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		typed_q = {typed_q, t};
		start <= 1'b1;
		kind <= k;
		from_state <= s;
		symbol <= c;
		to_state <= d;
		do @(posedge clk); while (busy);
		items_sent++;
		if (k == KIND_ADD)
			adds_sent++;
	endtask

	task automatic send_random(input kind_t k);
		send(k, state_idx_t'($urandom), pick_symbol(), state_idx_t'($urandom), EXP_PREDICTED);
	endtask

	// hold start low until every result is in and the last symbol scan is over
	task automatic settle();
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		if (!calm && $urandom_range(99) < 36) begin
			cfg_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic reconfigure();
		logic [CFG_DATA_BITS-1:0] val;
		settle();
		repeat ($urandom_range(1, 3)) begin
			val = CFG_DATA_BITS'($urandom);
			case ($urandom_range(5))
				0: begin
					val[STATE_BITS-1:0] = $urandom_range(1) ? '1 : '0;
					write_reg(CFG_START_STATE, val);
				end
				1: write_reg(CFG_START_STATE, val);
				2: write_reg(CFG_ACCEPT_MASK, $urandom_range(1) ? '1 : '0);
				3, 4: write_reg(CFG_ACCEPT_MASK, val);
				default: write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, val);
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_ADD;
		from_state <= '0;
		symbol <= '0;
		to_state <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_START_STATE;
		cfg_data <= '0;

		dir_rows = '{
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_REJECTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_SYMBOL, 4'hF, 8'hFF, 4'hF, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_BEGIN,  4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_REJECTED},
			'{1'b1, CFG_ACCEPT_MASK, 16'hFFFF, KIND_ADD,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'hF, 8'hFF, 4'hF, EXP_ACCEPTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_ADD,    4'h0, 8'h00, 4'hF, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_ADD,    4'hF, 8'hFF, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_ADD,    4'h0, 8'hFF, 4'hF, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_SYMBOL, 4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_SYMBOL, 4'h0, 8'hFF, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_SYMBOL, 4'hF, 8'hFF, 4'hF, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b1, CFG_START_STATE, 16'hFFFF, KIND_ADD,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b1, CFG_ACCEPT_MASK, 16'h8000, KIND_ADD,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_BEGIN,  4'hF, 8'hFF, 4'hF, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_SYMBOL, 4'h0, 8'h55, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b1, CFG_SPARE_HI,    16'hFFFF, KIND_ADD,    4'h0, 8'h00, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_BEGIN,  4'h0, 8'hAA, 4'h0, EXP_PREDICTED},
			'{1'b0, CFG_START_STATE, 16'h0000, KIND_END,    4'h0, 8'h00, 4'h0, EXP_PREDICTED}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				settle();
				write_reg(dir_rows[r].idx, dir_rows[r].data);
				cfg_valid <= 1'b0;
			end else begin
				send(dir_rows[r].kind, dir_rows[r].src, dir_rows[r].sym, dir_rows[r].dst,
					dir_rows[r].exp);
			end
		end

		foreach (sym_pool[i])
			sym_pool[i] = SYM_BITS'($urandom);

		while (items_sent < RANDOM_ITEMS + 20) begin
			calm = (items_sent > 400 && items_sent < 600);
			if ($urandom_range(4) == 0)
				reconfigure();
			if (adds_sent < STORE_DEPTH) begin
				repeat ($urandom_range(2, 10)) send_random(KIND_ADD);
			end else if ($urandom_range(9) == 0) begin
				send_random(KIND_ADD);
			end
			if ($urandom_range(99) < 85) begin
				send_random(KIND_BEGIN);
				repeat ($urandom_range(0, 6)) send_random(KIND_SYMBOL);
				send_random(KIND_END);
				// continue the word past its end
				if ($urandom_range(5) == 0) begin
					repeat ($urandom_range(1, 2)) send_random(KIND_SYMBOL);
					send_random(KIND_END);
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send(kind_t'($urandom_range(3)), state_idx_t'($urandom),
						SYM_BITS'($urandom), state_idx_t'($urandom), EXP_PREDICTED);
				end
			end
		end

		settle();
		if (errors == 0 && verdict_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
design/nssm_pkg.sv
design/nfa_symbol_stream_matcher.sv
design/nssm_checker.sv
dv/nfa_symbol_stream_matcher_tb.sv
